[rtl/jsu_pkg.sv]
package jsu_pkg;

   localparam int CODE_UNIT_BITS_DEF = 16;
   localparam int UNIT_W = 16;
   localparam int KIND_W = 3;

   localparam logic [1:0] MODE_TEXT = 2'd0;
   localparam logic [1:0] MODE_ESC  = 2'd1;
   localparam logic [1:0] MODE_HEX  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_CHAR         = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CLOSED       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_UNTERMINATED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BAD_ESCAPE   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BAD_HEX      = 3'd4;

   localparam logic [UNIT_W-1:0] CH_QUOTE     = 16'h0022;
   localparam logic [UNIT_W-1:0] CH_BACKSLASH = 16'h005C;
   localparam logic [UNIT_W-1:0] CH_SLASH     = 16'h002F;
   localparam logic [UNIT_W-1:0] CH_LOWER_B   = 16'h0062;
   localparam logic [UNIT_W-1:0] CH_LOWER_F   = 16'h0066;
   localparam logic [UNIT_W-1:0] CH_LOWER_N   = 16'h006E;
   localparam logic [UNIT_W-1:0] CH_LOWER_R   = 16'h0072;
   localparam logic [UNIT_W-1:0] CH_LOWER_T   = 16'h0074;
   localparam logic [UNIT_W-1:0] CH_LOWER_U   = 16'h0075;
   localparam logic [UNIT_W-1:0] CH_BS        = 16'h0008;
   localparam logic [UNIT_W-1:0] CH_FF        = 16'h000C;
   localparam logic [UNIT_W-1:0] CH_LF        = 16'h000A;
   localparam logic [UNIT_W-1:0] CH_CR        = 16'h000D;
   localparam logic [UNIT_W-1:0] CH_TAB       = 16'h0009;

   // digit value in [3:0], bit 4 set when not a hex digit
   function automatic logic [4:0] hex_value(input logic [UNIT_W-1:0] u);
      logic [4:0] d;
      d = 5'h10;
      if (u >= 16'h0030 && u <= 16'h0039) begin
         d = {1'b0, u[3:0]};
      end else if ((u >= 16'h0061 && u <= 16'h0066) || (u >= 16'h0041 && u <= 16'h0046)) begin
         d = {1'b0, u[3:0] + 4'd9};
      end
      return d;
   endfunction

endpackage

[rtl/json_string_unescape.sv]
// JSON string body decoder, one code unit per transfer.
// rsp_tvalid follows the req transfer through the input register, then the result register.
// One code unit per cycle unless rsp stalls; escape starts, first 3 hex digits emit nothing.
// The decode state lives in one register set updated as each unit leaves the input register.
// Reset (synchronous, active high) empties both registers and returns to plain text mode.
module json_string_unescape #(
   parameter int CODE_UNIT_BITS = jsu_pkg::CODE_UNIT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] out_char
   output logic [2:0]  rsp_tuser    // [2:0] kind
);

   logic                      in_vld_ff, in_vld_in;
   logic [jsu_pkg::UNIT_W-1:0] in_data_ff;
   logic                      in_last_ff;
   logic                      out_vld_ff, out_vld_in;
   logic [jsu_pkg::UNIT_W-1:0] out_char_ff, out_char_in;
   logic [jsu_pkg::KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [1:0]                mode_ff, mode_in;
   logic [1:0]                cnt_ff, cnt_in;
   logic [jsu_pkg::UNIT_W-1:0] acc_ff, acc_in;

   logic [jsu_pkg::UNIT_W-1:0] unit_mask;
   logic [jsu_pkg::UNIT_W-1:0] u;
   logic [jsu_pkg::UNIT_W-1:0] acc_next;
   logic [4:0]                digit;
   logic                      advance;
   logic                      emit;
   logic [jsu_pkg::UNIT_W-1:0] res_char;
   logic [jsu_pkg::KIND_W-1:0] res_kind;

   always_comb begin
      for (int i = 0; i < jsu_pkg::UNIT_W; i++) begin
         unit_mask[i] = (i < CODE_UNIT_BITS);
      end
   end

   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign in_vld_in  = req_tvalid ? 1'b1 : (in_vld_ff && !advance);

   assign u        = in_data_ff & unit_mask;
   assign digit    = jsu_pkg::hex_value(u);
   assign acc_next = {acc_ff[11:0], digit[3:0]};

   always_comb begin
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      emit     = 1'b0;
      res_char = '0;
      res_kind = jsu_pkg::KIND_CHAR;
      if (mode_ff == jsu_pkg::MODE_ESC) begin
         mode_in = jsu_pkg::MODE_TEXT;
         emit    = 1'b1;
         if (in_last_ff) begin
            res_kind = jsu_pkg::KIND_BAD_ESCAPE;
            cnt_in   = '0;
            acc_in   = '0;
         end else begin
            case (u)
               jsu_pkg::CH_QUOTE:     res_char = jsu_pkg::CH_QUOTE;
               jsu_pkg::CH_BACKSLASH: res_char = jsu_pkg::CH_BACKSLASH;
               jsu_pkg::CH_SLASH:     res_char = jsu_pkg::CH_SLASH;
               jsu_pkg::CH_LOWER_B:   res_char = jsu_pkg::CH_BS;
               jsu_pkg::CH_LOWER_F:   res_char = jsu_pkg::CH_FF;
               jsu_pkg::CH_LOWER_N:   res_char = jsu_pkg::CH_LF;
               jsu_pkg::CH_LOWER_R:   res_char = jsu_pkg::CH_CR;
               jsu_pkg::CH_LOWER_T:   res_char = jsu_pkg::CH_TAB;
               jsu_pkg::CH_LOWER_U: begin
                  mode_in = jsu_pkg::MODE_HEX;
                  cnt_in  = '0;
                  acc_in  = '0;
                  emit    = 1'b0;
               end
               default: begin
                  res_kind = jsu_pkg::KIND_BAD_ESCAPE;
                  cnt_in   = '0;
                  acc_in   = '0;
               end
            endcase
         end
      end else if (mode_ff == jsu_pkg::MODE_HEX) begin
         if (in_last_ff || digit[4]) begin
            mode_in  = jsu_pkg::MODE_TEXT;
            cnt_in   = '0;
            acc_in   = '0;
            emit     = 1'b1;
            res_kind = jsu_pkg::KIND_BAD_HEX;
         end else if (cnt_ff == 2'd3) begin
            mode_in  = jsu_pkg::MODE_TEXT;
            cnt_in   = '0;
            acc_in   = '0;
            emit     = 1'b1;
            res_char = acc_next & unit_mask;
         end else begin
            cnt_in = cnt_ff + 2'd1;
            acc_in = acc_next;
         end
      end else begin
         mode_in = jsu_pkg::MODE_TEXT;
         if (in_last_ff) begin
            emit     = 1'b1;
            res_kind = jsu_pkg::KIND_UNTERMINATED;
            cnt_in   = '0;
            acc_in   = '0;
         end else if (u == jsu_pkg::CH_BACKSLASH) begin
            mode_in = jsu_pkg::MODE_ESC;
         end else if (u == jsu_pkg::CH_QUOTE) begin
            emit     = 1'b1;
            res_kind = jsu_pkg::KIND_CLOSED;
            cnt_in   = '0;
            acc_in   = '0;
         end else begin
            emit     = 1'b1;
            res_char = u;
         end
      end
   end

   always_comb begin
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_char_in = out_char_ff;
      out_kind_in = out_kind_ff;
      if (advance) begin
         out_vld_in = emit;
         if (emit) begin
            out_char_in = res_char;
            out_kind_in = res_kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         mode_ff    <= jsu_pkg::MODE_TEXT;
         cnt_ff     <= '0;
         acc_ff     <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            mode_ff <= mode_in;
            cnt_ff  <= cnt_in;
            acc_ff  <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      out_char_ff <= out_char_in;
      out_kind_ff <= out_kind_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tuser  = out_kind_ff;

endmodule

[rtl/jsu_checker.sv]
module jsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= jsu_pkg::KIND_BAD_HEX))
      else $error("kind out of range");

   a_status_no_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != jsu_pkg::KIND_CHAR) |-> (rsp_tdata == 16'h0000))
      else $error("status transfer carries a character");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !rsp_tvalid && !$past(req_tvalid && req_tready)) |-> req_tready)
      else $error("input stalled with nothing pending");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
